// ===== design/pire_pkg.sv =====
// Shared types, widths and constants for the rotated-ellipse point test.
package pire_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int RAD_W     = COORD_W - 1;
  localparam int ANG_W     = 17;
  localparam int CFG_IDX_W = 3;

  // Point minus origin, focus offset and point-to-focus difference
  localparam int PD_W   = COORD_W + 1;
  localparam int OFS_W  = COORD_W + 2;
  localparam int DIFF_W = COORD_W + 2;

  // Pipelined square root: one result bit per stage
  localparam int SQ_OUT_W = DIFF_W;
  localparam int SQ_IN_W  = 2 * SQ_OUT_W;
  localparam int SQ_REM_W = SQ_OUT_W + 3;
  localparam int SQ_LAT   = SQ_OUT_W;
  localparam int SQR_W    = SQ_IN_W - 2;

  // Focal span product and scaled offsets
  localparam int NPROD_W = 2 * RAD_W + 1;
  localparam int TRIG_W  = 33;
  localparam int MAG_W   = TRIG_W - 1;
  localparam int PROD_W  = RAD_W + MAG_W;
  localparam int TRIG_FRAC = 30;

  // CORDIC
  localparam int CORDIC_STEPS = 18;
  localparam int CZ_W = 26;
  localparam int AR_W = 18;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [AR_W-1:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [AR_W-1:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [AR_W-1:0] QUARTER_TURN = 18'sd11520;
  localparam logic signed [CZ_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667,
    26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29
  };
  localparam int TRIG_LAT = CORDIC_STEPS + 2;

  // Pipeline latencies in register stages
  localparam int FOCUS_LAT = SQ_LAT + 3;
  localparam int PT_DELAY  = FOCUS_LAT;
  localparam int DIST_LAT  = SQ_LAT + 2;
  localparam int OUT_LAT   = PT_DELAY + DIST_LAT + 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE     = 3'd6;

  typedef enum logic [2:0] {
    FACE_XN   = 3'd0,
    FACE_XP   = 3'd1,
    FACE_YN   = 3'd2,
    FACE_YP   = 3'd3,
    FACE_ZN   = 3'd4,
    FACE_ZP   = 3'd5,
    FACE_NONE = 3'd6
  } face_t;

  // Focus-1 offset from the center plus the degenerate-ellipse flag
  typedef struct packed {
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic signed [OFS_W-1:0] oz;
    logic                    bad;
  } focus_t;

endpackage

// ===== design/pire_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module pire_sqrt import pire_pkg::*; (
  input  logic                clk,
  input  logic [SQ_IN_W-1:0]  radicand,
  output logic [SQ_OUT_W-1:0] root
);

  logic [SQ_REM_W-1:0] rem_q  [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_q [SQ_OUT_W];
  logic [SQ_IN_W-1:0]  src_q  [SQ_OUT_W];

  for (genvar g = 0; g < SQ_OUT_W; g++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_OUT_W-1:0] root_in;
    logic [SQ_IN_W-1:0]  src_in;
    logic                ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign src_in  = src_q[g-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[SQ_REM_W-3:0], src_in[SQ_IN_W-1 -: 2]};
    assign trial  = {{(SQ_REM_W-SQ_OUT_W-2){1'b0}}, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      rem_q[g]  <= ge ? rem_sh - trial : rem_sh;
      root_q[g] <= {root_in[SQ_OUT_W-2:0], ge};
      src_q[g]  <= src_in << 2;
    end
  end

  assign root = root_q[SQ_OUT_W-1];

endmodule

// ===== design/pire_cordic.sv =====
// Pipelined rotation CORDIC: angle in 1/128 degree to Q1.30 cosine and sine.
module pire_cordic import pire_pkg::*; (
  input  logic                     clk,
  input  logic signed [ANG_W-1:0]  angle,
  output logic signed [TRIG_W-1:0] cos_val,
  output logic signed [TRIG_W-1:0] sin_val
);

  logic signed [AR_W-1:0]   a0, r1, r2, r3, r4, r5;
  logic signed [AR_W+8:0]   zf;
  logic                     fold;
  logic signed [TRIG_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0]   z_q [CORDIC_STEPS+1];
  logic                     neg_q [CORDIC_STEPS+1];

  // wrap to one turn, center on zero, fold into +-90 degrees
  always_comb begin
    a0 = AR_W'(angle);
    r1 = (a0 < 0) ? a0 + FULL_TURN : a0;
    r2 = (r1 < 0) ? r1 + FULL_TURN : r1;
    r3 = (r2 >= FULL_TURN) ? r2 - FULL_TURN : r2;
    r4 = (r3 >= HALF_TURN) ? r3 - FULL_TURN : r3;
    fold = 1'b0;
    r5 = r4;
    if (r4 > QUARTER_TURN) begin
      r5 = r4 - HALF_TURN;
      fold = 1'b1;
    end else if (r4 < -QUARTER_TURN) begin
      r5 = r4 + HALF_TURN;
      fold = 1'b1;
    end
    zf = {r5, 9'b0};
  end

  always_ff @(posedge clk) begin
    x_q[0]   <= CORDIC_GAIN;
    y_q[0]   <= '0;
    z_q[0]   <= zf[CZ_W-1:0];
    neg_q[0] <= fold;
  end

  // one micro-rotation per stage
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    always_ff @(posedge clk) begin
      if (z_q[g] >= 0) begin
        x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
        y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
        z_q[g+1] <= z_q[g] - ATAN_TAB[g];
      end else begin
        x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
        y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
        z_q[g+1] <= z_q[g] + ATAN_TAB[g];
      end
      neg_q[g+1] <= neg_q[g];
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    cos_val <= neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    sin_val <= neg_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
  end

endmodule

// ===== design/pire_focus.sv =====
// Focus offset pipeline: focal span, rotation and face mapping from config.
module pire_focus import pire_pkg::*; (
  input  logic                    clk,
  input  logic [RAD_W-1:0]        minor_radius,
  input  logic [RAD_W-1:0]        major_radius,
  input  logic signed [ANG_W-1:0] rotation_angle,
  input  face_t                   face_select,
  output focus_t                  foc
);

  logic [NPROD_W-1:0]       span_sq;
  logic                     bad;
  logic [SQ_OUT_W-1:0]      span_root;
  logic [RAD_W-1:0]         span;
  logic signed [TRIG_W-1:0] cos_val, sin_val;
  logic [MAG_W-1:0]         c_mag, s_mag;
  logic [PROD_W-1:0]        c_prod, s_prod;
  logic                     c_neg, s_neg;
  logic [PROD_W:0]          c_rnd, s_rnd;
  logic signed [OFS_W-1:0]  c_ofs, s_ofs;
  logic signed [OFS_W-1:0]  ox_next, oy_next, oz_next;

  // major^2 - minor^2 as (major-minor)*(major+minor)
  always_ff @(posedge clk) begin
    span_sq <= NPROD_W'(RAD_W'(major_radius - minor_radius)
               * ({1'b0, major_radius} + {1'b0, minor_radius}));
    bad     <= major_radius < minor_radius;
  end

  pire_sqrt u_span_sqrt (
    .clk      (clk),
    .radicand ({{(SQ_IN_W-NPROD_W){1'b0}}, span_sq}),
    .root     (span_root)
  );
  assign span = span_root[RAD_W-1:0];

  pire_cordic u_cordic (
    .clk     (clk),
    .angle   (rotation_angle),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  assign c_mag = cos_val[TRIG_W-1] ? MAG_W'(-cos_val) : MAG_W'(cos_val);
  assign s_mag = sin_val[TRIG_W-1] ? MAG_W'(-sin_val) : MAG_W'(sin_val);

  // scale magnitudes by the focal span
  always_ff @(posedge clk) begin
    c_prod <= span * c_mag;
    s_prod <= span * s_mag;
    c_neg  <= cos_val[TRIG_W-1];
    s_neg  <= sin_val[TRIG_W-1];
  end

  // round half away from zero, drop trig fraction, restore sign
  always_comb begin
    c_rnd = {1'b0, c_prod} + (PROD_W+1)'(1 << (TRIG_FRAC-1));
    s_rnd = {1'b0, s_prod} + (PROD_W+1)'(1 << (TRIG_FRAC-1));
    c_ofs = OFS_W'(c_rnd >> TRIG_FRAC);
    s_ofs = OFS_W'(s_rnd >> TRIG_FRAC);
    if (c_neg) c_ofs = -c_ofs;
    if (s_neg) s_ofs = -s_ofs;
  end

  // per-face sign pattern
  always_comb begin
    ox_next = '0;
    oy_next = '0;
    oz_next = '0;
    unique case (face_select)
      FACE_XN: begin
        oy_next = c_ofs;
        oz_next = -s_ofs;
      end
      FACE_XP: begin
        oy_next = -c_ofs;
        oz_next = -s_ofs;
      end
      FACE_YN: begin
        ox_next = -s_ofs;
        oz_next = c_ofs;
      end
      FACE_YP: begin
        ox_next = s_ofs;
        oz_next = c_ofs;
      end
      FACE_ZN: begin
        ox_next = c_ofs;
        oy_next = -s_ofs;
      end
      FACE_ZP: begin
        ox_next = c_ofs;
        oy_next = s_ofs;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    foc.ox  <= ox_next;
    foc.oy  <= oy_next;
    foc.oz  <= oz_next;
    foc.bad <= bad;
  end

endmodule

// ===== design/pire_dist.sv =====
// Euclidean distance pipeline: squares, sum, floor square root.
module pire_dist import pire_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid_in,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  input  logic signed [DIFF_W-1:0] dz,
  output logic                     valid_out,
  output logic [SQ_OUT_W-1:0]      distance
);

  logic signed [SQ_IN_W-1:0] px, py, pz;
  logic [SQR_W-1:0]          sq_x, sq_y, sq_z;
  logic [SQ_IN_W-1:0]        sum;
  logic [DIST_LAT-1:0]       vld;

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    sq_x <= px[SQR_W-1:0];
    sq_y <= py[SQR_W-1:0];
    sq_z <= pz[SQR_W-1:0];
    sum  <= {2'b0, sq_x} + {2'b0, sq_y} + {2'b0, sq_z};
  end

  pire_sqrt u_sqrt (
    .clk      (clk),
    .radicand (sum),
    .root     (distance)
  );

  // beat valid follows the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIST_LAT-2:0], valid_in};
    end
  end
  assign valid_out = vld[DIST_LAT-1];

endmodule

// ===== design/point_in_rotated_ellipse_test.sv =====
// Top level: config registers, point pipeline and focal-distance compare.
//
// Usage: raise start with point_x/y/z for one cycle to issue a beat; busy is
// low except during reset, so one point is taken on every cycle that start
// is high. Each point yields one result: done pulses for one cycle with
// is_inside valid in that same cycle. Results leave in issue order; the
// receiver cannot stall and none is held. Throughput is one point per clock.
// Latency is set by the focus path (a 34-stage square root for the focal span
// plus scaling, 37 stages, that the point waits on) and the distance path
// (squares, sum and another 34-stage square root), plus the difference and
// compare stages.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
// next edge; write them only while no point is in flight. An unused index
// is ignored.
// Reset (rst, synchronous) clears all beat valids and loads the register
// defaults: origin and radii zero, angle zero, no face (sphere test).
module point_in_rotated_ellipse_test import pire_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_W-1:0]   point_x,
  input  logic signed [COORD_W-1:0]   point_y,
  input  logic signed [COORD_W-1:0]   point_z,
  output logic                        done,
  output logic                        is_inside,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_data
);

  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic [RAD_W-1:0]          minor_radius, major_radius;
  logic signed [ANG_W-1:0]   rotation_angle;
  face_t                     face_select;
  focus_t                    foc;
  logic                      accept;

  logic signed [PD_W-1:0]    pt_x [PT_DELAY];
  logic signed [PD_W-1:0]    pt_y [PT_DELAY];
  logic signed [PD_W-1:0]    pt_z [PT_DELAY];
  logic [PT_DELAY-1:0]       pt_v;

  logic signed [DIFF_W:0]    t1x, t1y, t1z, t2x, t2y, t2z;
  logic signed [DIFF_W-1:0]  d1x, d1y, d1z, d2x, d2y, d2z;
  logic                      diff_v;
  logic                      v1, v2;
  logic [SQ_OUT_W-1:0]       dist1, dist2;
  logic [SQ_OUT_W:0]         dsum;
  logic [SQ_OUT_W:0]         lim;

  // no beat is taken while in reset
  assign busy   = rst;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      origin_z       <= '0;
      minor_radius   <= '0;
      major_radius   <= '0;
      rotation_angle <= '0;
      face_select    <= FACE_NONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x       <= cfg_data;
        CFG_ORIGIN_Y: origin_y       <= cfg_data;
        CFG_ORIGIN_Z: origin_z       <= cfg_data;
        CFG_MINOR:    minor_radius   <= cfg_data[RAD_W-1:0];
        CFG_MAJOR:    major_radius   <= cfg_data[RAD_W-1:0];
        CFG_ANGLE:    rotation_angle <= cfg_data[ANG_W-1:0];
        CFG_FACE:     face_select    <= face_t'(cfg_data[2:0]);
        default: begin
        end
      endcase
    end
  end

  pire_focus u_focus (
    .clk            (clk),
    .minor_radius   (minor_radius),
    .major_radius   (major_radius),
    .rotation_angle (rotation_angle),
    .face_select    (face_select),
    .foc            (foc)
  );

  // point relative to center, delayed until the focus offsets settle
  always_ff @(posedge clk) begin
    pt_x[0] <= PD_W'(point_x) - PD_W'(origin_x);
    pt_y[0] <= PD_W'(point_y) - PD_W'(origin_y);
    pt_z[0] <= PD_W'(point_z) - PD_W'(origin_z);
    for (int i = 1; i < PT_DELAY; i++) begin
      pt_x[i] <= pt_x[i-1];
      pt_y[i] <= pt_y[i-1];
      pt_z[i] <= pt_z[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_v <= '0;
    end else begin
      pt_v <= {pt_v[PT_DELAY-2:0], accept};
    end
  end

  // differences to both foci
  always_comb begin
    t1x = (DIFF_W+1)'(pt_x[PT_DELAY-1]) - (DIFF_W+1)'(foc.ox);
    t1y = (DIFF_W+1)'(pt_y[PT_DELAY-1]) - (DIFF_W+1)'(foc.oy);
    t1z = (DIFF_W+1)'(pt_z[PT_DELAY-1]) - (DIFF_W+1)'(foc.oz);
    t2x = (DIFF_W+1)'(pt_x[PT_DELAY-1]) + (DIFF_W+1)'(foc.ox);
    t2y = (DIFF_W+1)'(pt_y[PT_DELAY-1]) + (DIFF_W+1)'(foc.oy);
    t2z = (DIFF_W+1)'(pt_z[PT_DELAY-1]) + (DIFF_W+1)'(foc.oz);
  end

  always_ff @(posedge clk) begin
    d1x <= t1x[DIFF_W-1:0];
    d1y <= t1y[DIFF_W-1:0];
    d1z <= t1z[DIFF_W-1:0];
    d2x <= t2x[DIFF_W-1:0];
    d2y <= t2y[DIFF_W-1:0];
    d2z <= t2z[DIFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_v <= 1'b0;
    end else begin
      diff_v <= pt_v[PT_DELAY-1];
    end
  end

  pire_dist u_dist1 (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (diff_v),
    .dx        (d1x),
    .dy        (d1y),
    .dz        (d1z),
    .valid_out (v1),
    .distance  (dist1)
  );

  pire_dist u_dist2 (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (diff_v),
    .dx        (d2x),
    .dy        (d2y),
    .dz        (d2z),
    .valid_out (v2),
    .distance  (dist2)
  );

  // focal sum against twice the major radius
  assign dsum = {1'b0, dist1} + {1'b0, dist2};
  assign lim  = (SQ_OUT_W+1)'({major_radius, 1'b0});

  always_ff @(posedge clk) begin
    is_inside <= !foc.bad && (dsum <= lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1 && v2;
    end
  end

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##OUT_LAT done)
    else $error("accepted beat produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, OUT_LAT))
    else $error("result without a matching accepted beat");

  a_degenerate_outside: assert property (@(posedge clk) disable iff (rst)
    (done && is_inside) |-> (major_radius >= minor_radius))
    else $error("inside reported for major below minor");
`endif

endmodule

// ===== tb/tb_point_in_rotated_ellipse_test.sv =====
// Testbench for the rotated-ellipse point test: queued driver, predictor and result check.
module tb_point_in_rotated_ellipse_test import pire_pkg::*; ;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  localparam longint ARCTAN_DEG16 [18] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst, start, busy, done, is_inside, cfg_wr_en;
  logic [COORD_W-1:0] point_x, point_y, point_z, cfg_data;
  logic [CFG_IDX_W-1:0] cfg_index;

  point_t pending_points[$];
  bit     inside_expected[$];
  int     errors, cycles, gap_left;
  bit     taken, quiet, hold_feed;

  // shadow copy of the configuration
  longint     org_x, org_y, org_z, ang;
  longint     minor_r, major_r;
  logic [2:0] face;

  point_in_rotated_ellipse_test dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r, t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  // rotation CORDIC, Q1.30 cos/sin
  function automatic void cordic(input longint a, output longint cs, output longint sn);
    longint r, x, y, z, dx, dy;
    bit neg;
    r = a % 46080;
    neg = 0;
    if (r < 0) r += 46080;
    if (r >= 23040) r -= 46080;
    if (r > 11520) begin
      r -= 23040; neg = 1;
    end else if (r < -11520) begin
      r += 23040; neg = 1;
    end
    z = r * 512;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_DEG16[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN_DEG16[i];
      end
    end
    cs = neg ? -x : x;
    sn = neg ? -y : y;
  endfunction

  function automatic longint scale_offset(logic [63:0] f, longint c);
    logic [127:0] p;
    longint mag;
    mag = (c < 0) ? -c : c;
    p = ({64'd0, f} * {64'd0, mag}) + (128'd1 << 29);
    p = p >> 30;
    return (c < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] focal_dist(longint dx, longint dy, longint dz);
    logic [127:0] ax, ay, az;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    az = (dz < 0) ? -dz : dz;
    return isqrt(ax * ax + ay * ay + az * az);
  endfunction

  function automatic bit predict_inside(point_t p);
    longint px, py, pz, cs, sn, c, s, ox, oy, oz;
    logic [63:0] f, d1, d2;
    px = longint'($signed(p.x)) - org_x;
    py = longint'($signed(p.y)) - org_y;
    pz = longint'($signed(p.z)) - org_z;
    if (major_r < minor_r) return 0;
    f = isqrt((major_r - minor_r) * (major_r + minor_r));
    cordic(ang, cs, sn);
    c = scale_offset(f, cs);
    s = scale_offset(f, sn);
    ox = 0; oy = 0; oz = 0;
    case (face)
      FACE_XN: begin oy = c;  oz = -s; end
      FACE_XP: begin oy = -c; oz = -s; end
      FACE_YN: begin ox = -s; oz = c;  end
      FACE_YP: begin ox = s;  oz = c;  end
      FACE_ZN: begin ox = c;  oy = -s; end
      FACE_ZP: begin ox = c;  oy = s;  end
      default: ;
    endcase
    d1 = focal_dist(px - ox, py - oy, pz - oz);
    d2 = focal_dist(px + ox, py + oy, pz + oz);
    return ({64'd0, d1} + {64'd0, d2} <= 128'(2 * major_r));
  endfunction

  // driver: one beat per accepted item, random idle bursts
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
      gap_left <= 0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        start <= 0;
        gap_left <= gap_left - 1;
      end else if (!hold_feed && pending_points.size() > 0) begin
        point_t p;
        p = pending_points.pop_front();
        point_x <= p.x; point_y <= p.y; point_z <= p.z;
        start <= 1;
        if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 7);
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: predict on acceptance, check on done
  always @(posedge clk) begin
    cycles <= cycles + 1;
    taken <= start && !busy && !rst;
    if (!rst && start && !busy) begin
      point_t p;
      p.x = point_x; p.y = point_y; p.z = point_z;
      inside_expected.push_back(predict_inside(p));
    end
    if (!rst && done) begin
      if (inside_expected.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result beat, is_inside=%0b", is_inside);
      end else begin
        bit e;
        e = inside_expected.pop_front();
        if (e !== is_inside) begin
          errors <= errors + 1;
          if (errors < 10) $display("is_inside mismatch: expected %0b got %0b", e, is_inside);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      CFG_ORIGIN_X: org_x = longint'($signed(val));
      CFG_ORIGIN_Y: org_y = longint'($signed(val));
      CFG_ORIGIN_Z: org_z = longint'($signed(val));
      CFG_MINOR:    minor_r = longint'(val[RAD_W-1:0]);
      CFG_MAJOR:    major_r = longint'(val[RAD_W-1:0]);
      CFG_ANGLE:    ang = longint'($signed(val[ANG_W-1:0]));
      CFG_FACE:     face = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic wait_idle();
    while (pending_points.size() > 0 || start || inside_expected.size() > 0) @(posedge clk);
    repeat (OUT_LAT + 5) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_radius();
    return $urandom & ((32'd1 << $urandom_range(4, 31)) - 1);
  endfunction

  // point around the center, spread about twice the major radius
  function automatic logic [COORD_W-1:0] near(longint c);
    int sh;
    longint m;
    m = major_r + 1;
    sh = 30;
    while (sh > 0 && m > 1) begin
      m = m >> 1; sh--;
    end
    return COORD_W'(c + (longint'($signed($urandom())) >>> sh));
  endfunction

  task automatic add_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    pending_points.push_back(p);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        add_point($urandom, $urandom, $urandom);
      else
        add_point(near(org_x), near(org_y), near(org_z));
    end
  endtask

  initial begin
    logic [COORD_W-1:0] mn, mj;
    rst = 1; start = 0; cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
    point_x = 0; point_y = 0; point_z = 0;
    errors = 0; cycles = 0; taken = 0; quiet = 0; hold_feed = 0; gap_left = 0;
    org_x = 0; org_y = 0; org_z = 0; minor_r = 0; major_r = 0; ang = 0;
    face = FACE_NONE;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset defaults: zero-radius sphere at the origin
    add_point(0, 0, 0);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(1, 0, 0);
    wait_idle();

    // directed: one ellipse on every face, then the odd cases
    write_reg(CFG_MAJOR, 32'h0005_0000);
    write_reg(CFG_MINOR, 32'h0003_0000);
    write_reg(CFG_ANGLE, 32'd5760);
    for (int fc = 0; fc < 8; fc++) begin
      write_reg(CFG_FACE, COORD_W'(fc));
      add_point(32'h0004_8000, 0, 0);
      add_point(0, 32'h0004_8000, 0);
      add_point(0, 0, 32'h0004_8000);
      wait_idle();
    end
    // major below minor
    write_reg(CFG_MINOR, 32'h0006_0000);
    add_point(0, 0, 0);
    add_point(32'h7fff_ffff, 32'h8000_0000, 0);
    wait_idle();
    // angle extremes and wrap, radius extremes, unknown index
    write_reg(CFG_MINOR, 0);
    write_reg(CFG_MAJOR, 32'hffff_ffff);
    write_reg(CFG_ANGLE, -32'sd46080);
    write_reg(3'd7, 32'hdead_beef);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    wait_idle();
    write_reg(CFG_ANGLE, 32'd46079);
    write_reg(CFG_ORIGIN_X, 32'h7fff_ffff);
    write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
    write_reg(CFG_ORIGIN_Z, 32'hffff_ffff);
    add_point(32'h8000_0000, 32'h7fff_ffff, 0);
    add_point(0, 0, 0);
    wait_idle();

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      mj = rand_radius();
      mn = ($urandom_range(0, 7) == 0) ? rand_radius() : (mj >> $urandom_range(0, 8));
      write_reg(CFG_MAJOR, mj);
      write_reg(CFG_MINOR, mn);
      write_reg(CFG_ANGLE,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 92159) - 46080);
      write_reg(CFG_FACE, $urandom_range(0, 7));
      write_reg(CFG_ORIGIN_X, ($urandom_range(0, 1)) ? $urandom : $urandom >>> 8);
      write_reg(CFG_ORIGIN_Y, ($urandom_range(0, 1)) ? $urandom : $urandom >>> 8);
      write_reg(CFG_ORIGIN_Z, ($urandom_range(0, 1)) ? $urandom : $urandom >>> 8);
      if (ph == 13) quiet = 1;
      add_random(48);
      // hold the feed until the pipeline drains
      if (ph == 6) begin
        repeat (20) @(posedge clk);
        hold_feed = 1;
        while (inside_expected.size() > 0) @(posedge clk);
        hold_feed = 0;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
